### hw/rtl/second_order_state_space_filter_unit_macros.svh
// Assertion helpers for the state-space filter checks.
`ifndef SECOND_ORDER_STATE_SPACE_FILTER_UNIT_MACROS_SVH
`define SECOND_ORDER_STATE_SPACE_FILTER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SOSF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sosf check failed");

// next-cycle implication
`define SOSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sosf check failed");

`endif

### hw/rtl/sosf_pkg.sv
package sosf_pkg;

	// configuration register map
	typedef enum logic [2:0] {
		REG_A_ROW_FIRST  = 3'd0,
		REG_A_ROW_SECOND = 3'd1,
		REG_B_PAIR       = 3'd2,
		REG_C_ROW_FIRST  = 3'd3,
		REG_C_ROW_SECOND = 3'd4,
		REG_D_PAIR       = 3'd5
	} reg_idx_t;

	localparam int CFG_DATA_WIDTH = 64;
	localparam int CFG_HALF       = 32;

	// rounded products are limited to +/- 2^60 before summing
	localparam int PROD_CLAMP_EXP = 60;
	localparam int TERM_WIDTH     = PROD_CLAMP_EXP + 2;
	// three terms summed
	localparam int SUM_WIDTH      = TERM_WIDTH + 2;

endpackage

### hw/rtl/second_order_state_space_filter_unit.sv
// Second-order state-space resonator filter.
// Input channel: in_valid / in_stall with one signed sample per beat.
// Output channel: out_valid / out_stall with in_phase, quadrature and the
// saturated flag per beat; one result for every accepted sample.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects one
// of six 64-bit coefficient registers, indexes six and seven are dropped.
// Write coefficients only while no sample is in flight.
// A sample waits in the input register, and its result is registered in the
// result register once that register no longer holds a stalled beat.
// Throughput: one sample per cycle without receiver stalls. The state update
// loops through four coefficient-by-state multipliers, two input multipliers,
// rounding, a three-term add and saturation; this loop sets the clock.
// Reset clears the coefficients, both state values and all valid flags.
// When the receiver stalls, the result register holds; one more sample may
// enter the input register, after which in_stall rises until the result
// beat is taken.
module second_order_state_space_filter_unit #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 32,
	parameter int STATE_WIDTH  = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]        in_phase,
	output logic signed [SAMPLE_WIDTH-1:0]        quadrature,
	output logic                                  saturated,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [2:0]                            cfg_index,
	input  logic [sosf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

	localparam int SAMPLE_FRAC = SAMPLE_WIDTH - 1;
	localparam int COEF_FRAC   = COEF_WIDTH - 4;
	localparam int STATE_FRAC  = STATE_WIDTH - 8;
	localparam int SH_OUT_X    = COEF_FRAC + STATE_FRAC - SAMPLE_FRAC;
	localparam int SH_OUT_U    = COEF_FRAC;
	localparam int SH_ST_X     = COEF_FRAC;
	localparam int SH_ST_U     = COEF_FRAC + SAMPLE_FRAC - STATE_FRAC;
	localparam int SW          = sosf_pkg::SUM_WIDTH;
	localparam int HI          = sosf_pkg::CFG_HALF;

	localparam logic signed [SW-1:0] Y_TOP =
		{{(SW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] X_TOP =
		{{(SW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};

	logic [sosf_pkg::CFG_DATA_WIDTH-1:0] a_row_first_q;
	logic [sosf_pkg::CFG_DATA_WIDTH-1:0] a_row_second_q;
	logic [sosf_pkg::CFG_DATA_WIDTH-1:0] b_pair_q;
	logic [sosf_pkg::CFG_DATA_WIDTH-1:0] c_row_first_q;
	logic [sosf_pkg::CFG_DATA_WIDTH-1:0] c_row_second_q;
	logic [sosf_pkg::CFG_DATA_WIDTH-1:0] d_pair_q;

	logic                            valid_s1;
	logic signed [SAMPLE_WIDTH-1:0]  sample_s1;
	logic signed [STATE_WIDTH-1:0]   state_first_q;
	logic signed [STATE_WIDTH-1:0]   state_second_q;
	logic                            out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]  in_phase_q;
	logic signed [SAMPLE_WIDTH-1:0]  quadrature_q;
	logic                            saturated_q;
	logic                            advance;

	// rows: in_phase, quadrature, next state_first, next state_second
	logic signed [COEF_WIDTH-1:0]    cu  [4];
	logic signed [COEF_WIDTH-1:0]    cx0 [4];
	logic signed [COEF_WIDTH-1:0]    cx1 [4];
	logic signed [SW-1:0]            sum [4];
	logic signed [SW-1:0]            lim [4];
	logic [3:0]                      clip;

	assign cu[0]  = d_pair_q[HI +: COEF_WIDTH];
	assign cu[1]  = d_pair_q[0 +: COEF_WIDTH];
	assign cu[2]  = b_pair_q[HI +: COEF_WIDTH];
	assign cu[3]  = b_pair_q[0 +: COEF_WIDTH];
	assign cx0[0] = c_row_first_q[HI +: COEF_WIDTH];
	assign cx1[0] = c_row_first_q[0 +: COEF_WIDTH];
	assign cx0[1] = c_row_second_q[HI +: COEF_WIDTH];
	assign cx1[1] = c_row_second_q[0 +: COEF_WIDTH];
	assign cx0[2] = a_row_first_q[HI +: COEF_WIDTH];
	assign cx1[2] = a_row_first_q[0 +: COEF_WIDTH];
	assign cx0[3] = a_row_second_q[HI +: COEF_WIDTH];
	assign cx1[3] = a_row_second_q[0 +: COEF_WIDTH];

	genvar k;
	generate
		for (k = 0; k < 4; k++) begin : g_row
			localparam int SHU = (k < 2) ? SH_OUT_U : SH_ST_U;
			localparam int SHX = (k < 2) ? SH_OUT_X : SH_ST_X;
			localparam logic signed [SW-1:0] TOP = (k < 2) ? Y_TOP : X_TOP;
			logic signed [sosf_pkg::TERM_WIDTH-1:0] tu;
			logic signed [sosf_pkg::TERM_WIDTH-1:0] t0;
			logic signed [sosf_pkg::TERM_WIDTH-1:0] t1;

			sosf_term #(.AW(COEF_WIDTH), .BW(SAMPLE_WIDTH), .SHIFT(SHU)) u_tu (
				.a(cu[k]), .b(sample_s1), .term(tu)
			);
			sosf_term #(.AW(COEF_WIDTH), .BW(STATE_WIDTH), .SHIFT(SHX)) u_t0 (
				.a(cx0[k]), .b(state_first_q), .term(t0)
			);
			sosf_term #(.AW(COEF_WIDTH), .BW(STATE_WIDTH), .SHIFT(SHX)) u_t1 (
				.a(cx1[k]), .b(state_second_q), .term(t1)
			);

			assign sum[k] = SW'(tu) + SW'(t0) + SW'(t1);

			always_comb begin
				clip[k] = 1'b1;
				if (sum[k] > TOP) begin
					lim[k] = TOP;
				end else if (sum[k] < ~TOP) begin
					lim[k] = ~TOP;
				end else begin
					lim[k]  = sum[k];
					clip[k] = 1'b0;
				end
			end
		end
	endgenerate

	// result register frees up unless it holds a stalled beat
	assign advance   = !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_row_first_q  <= '0;
			a_row_second_q <= '0;
			b_pair_q       <= '0;
			c_row_first_q  <= '0;
			c_row_second_q <= '0;
			d_pair_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sosf_pkg::REG_A_ROW_FIRST:  a_row_first_q  <= cfg_data;
				sosf_pkg::REG_A_ROW_SECOND: a_row_second_q <= cfg_data;
				sosf_pkg::REG_B_PAIR:       b_pair_q       <= cfg_data;
				sosf_pkg::REG_C_ROW_FIRST:  c_row_first_q  <= cfg_data;
				sosf_pkg::REG_C_ROW_SECOND: c_row_second_q <= cfg_data;
				sosf_pkg::REG_D_PAIR:       d_pair_q       <= cfg_data;
				default: ; // drop writes past the map
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			state_first_q  <= '0;
			state_second_q <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (advance && valid_s1) begin
				state_first_q  <= lim[2][STATE_WIDTH-1:0];
				state_second_q <= lim[3][STATE_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample;
		end
		if (advance && valid_s1) begin
			in_phase_q   <= lim[0][SAMPLE_WIDTH-1:0];
			quadrature_q <= lim[1][SAMPLE_WIDTH-1:0];
			saturated_q  <= |clip;
		end
	end

	assign out_valid  = out_valid_q;
	assign in_phase   = in_phase_q;
	assign quadrature = quadrature_q;
	assign saturated  = saturated_q;

endmodule

### hw/rtl/sosf_term.sv
module sosf_term #(
	parameter int AW    = 32,
	parameter int BW    = 32,
	parameter int SHIFT = 28
) (
	input  logic signed [AW-1:0]                     a,
	input  logic signed [BW-1:0]                     b,
	output logic signed [sosf_pkg::TERM_WIDTH-1:0]   term
);

	localparam int PW   = AW + BW;
	localparam int GROW = (SHIFT > 0) ? 1 : 1 - SHIFT;
	localparam int RW   = PW + GROW;
	localparam int EW   = (RW > sosf_pkg::TERM_WIDTH) ? RW : sosf_pkg::TERM_WIDTH;
	localparam logic signed [EW-1:0] LIM = EW'(1) <<< sosf_pkg::PROD_CLAMP_EXP;

	logic signed [PW-1:0] prod;
	logic signed [EW-1:0] wide_v;
	logic signed [EW-1:0] clamped;

	assign prod = a * b;

	generate
		if (SHIFT > 0) begin : g_round
			localparam logic signed [RW-1:0] HALF = RW'(1) <<< (SHIFT - 1);
			logic signed [RW-1:0] biased;
			logic signed [RW-1:0] rounded;
			// nearest, ties away from zero: drop one from the bias on negative products
			assign biased  = RW'(prod) + HALF - {{(RW-1){1'b0}}, prod[PW-1]};
			assign rounded = biased >>> SHIFT;
			assign wide_v  = EW'(rounded);
		end else begin : g_scale_up
			assign wide_v = EW'(prod) <<< (-SHIFT);
		end
	endgenerate

	always_comb begin
		if (wide_v > LIM) begin
			clamped = LIM;
		end else if (wide_v < -LIM) begin
			clamped = -LIM;
		end else begin
			clamped = wide_v;
		end
	end

	assign term = clamped[sosf_pkg::TERM_WIDTH-1:0];

endmodule

### hw/rtl/sosf_checker.sv
`include "second_order_state_space_filter_unit_macros.svh"

module sosf_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [SAMPLE_WIDTH-1:0]  in_phase,
	input logic [SAMPLE_WIDTH-1:0]  quadrature,
	input logic                     saturated
);

	// a held result beat keeps its payload
	`SOSF_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(in_phase) && $stable(quadrature) && $stable(saturated))

	// input backs up only behind a stalled result
	`SOSF_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)

	// a fresh result follows an accepted sample via the input and result registers
	`SOSF_ASSERT_SAME(a_latency, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind second_order_state_space_filter_unit sosf_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sosf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.in_phase   (in_phase),
	.quadrature (quadrature),
	.saturated  (saturated)
);

### tb/tb_second_order_state_space_filter_unit.sv
`timescale 1ns / 1ps

module tb_second_order_state_space_filter_unit;

	localparam int COEF_FRAC     = 28;
	localparam int STATE_FRAC    = 24;
	localparam int SAMPLE_FRAC   = 15;
	localparam int SH_OUT_U      = COEF_FRAC;
	localparam int SH_OUT_X      = COEF_FRAC + STATE_FRAC - SAMPLE_FRAC;
	localparam int SH_ST_U       = COEF_FRAC + SAMPLE_FRAC - STATE_FRAC;
	localparam int SH_ST_X       = COEF_FRAC;
	localparam int PROD_LIM_EXP  = 60;
	localparam int NUM_COEF_REGS = 6;
	localparam logic [2:0] IDX_SPARE_SIX   = 3'd6;
	localparam logic [2:0] IDX_SPARE_SEVEN = 3'd7;

	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 120;
	localparam int STALL_LIMIT   = 2000;
	localparam int IDLE_PCT      = 34;
	localparam int MAX_REPORTS   = 40;

	localparam logic [31:0] Q28_ONE      = 32'h1000_0000;
	localparam logic [31:0] Q28_HALF     = 32'h0800_0000;
	localparam logic [31:0] Q28_NEG_HALF = 32'hF800_0000;
	localparam logic [31:0] Q28_EIGHTH   = 32'h0200_0000;
	localparam logic [31:0] COEF_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0] COEF_MIN     = 32'h8000_0000;
	localparam logic [31:0] ZERO_COEF    = 32'h0000_0000;

	typedef struct packed {
		logic signed [15:0] in_phase;
		logic signed [15:0] quadrature;
		logic               saturated;
	} filter_result_t;

	logic                                 clk        = 1'b0;
	logic                                 arst_n     = 1'b0;
	logic                                 in_valid   = 1'b0;
	logic                                 in_stall;
	logic signed [15:0]                   sample     = '0;
	logic                                 out_valid;
	logic                                 out_stall  = 1'b0;
	logic signed [15:0]                   in_phase;
	logic signed [15:0]                   quadrature;
	logic                                 saturated;
	logic                                 cfg_valid  = 1'b0;
	logic                                 cfg_ready;
	logic [2:0]                           cfg_index  = '0;
	logic [sosf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data   = '0;

	// shadow of the coefficient registers and filter state
	logic [63:0]        coef_bank [NUM_COEF_REGS];
	longint signed      state_first_q;
	longint signed      state_second_q;
	filter_result_t     pending_outputs [$];

	int  mismatch_count = 0;
	int  result_count   = 0;
	int  quiet_cycles   = 0;
	bit  no_idle        = 1'b0;
	bit  long_hold      = 1'b0;
	event long_hold_go;

	second_order_state_space_filter_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.in_phase   (in_phase),
		.quadrature (quadrature),
		.saturated  (saturated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic longint signed coef_hi(logic [63:0] r);
		return longint'($signed(r[63:32]));
	endfunction

	function automatic longint signed coef_lo(logic [63:0] r);
		return longint'($signed(r[31:0]));
	endfunction

	// product scaled down by 2^sh, rounded half away from zero, clamped to 2^60
	function automatic longint signed round_mul(longint signed a, longint signed b, int sh);
		logic [127:0] ma, mb, p;
		logic         neg;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? 128'(-a) : 128'(a);
		mb = (b < 0) ? 128'(-b) : 128'(b);
		p = ma * mb;
		p = (p + (128'd1 << (sh - 1))) >> sh;
		if (p > (128'd1 << PROD_LIM_EXP))
			p = 128'd1 << PROD_LIM_EXP;
		return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
	endfunction

	function automatic longint signed clamp_signed(longint signed v, int w, inout bit clipped);
		longint signed top, bottom;
		top = (longint'(1) <<< (w - 1)) - 1;
		bottom = -top - 1;
		if (v > top) begin
			clipped = 1'b1;
			return top;
		end
		if (v < bottom) begin
			clipped = 1'b1;
			return bottom;
		end
		return v;
	endfunction

	function automatic filter_result_t advance_filter(logic signed [15:0] s);
		longint signed  u, x0, x1, y0, y1, n0, n1;
		bit             clipped;
		filter_result_t r;
		u = longint'(s);
		x0 = state_first_q;
		x1 = state_second_q;
		clipped = 1'b0;
		y0 = round_mul(coef_hi(coef_bank[sosf_pkg::REG_D_PAIR]), u, SH_OUT_U)
		   + round_mul(coef_hi(coef_bank[sosf_pkg::REG_C_ROW_FIRST]), x0, SH_OUT_X)
		   + round_mul(coef_lo(coef_bank[sosf_pkg::REG_C_ROW_FIRST]), x1, SH_OUT_X);
		y1 = round_mul(coef_lo(coef_bank[sosf_pkg::REG_D_PAIR]), u, SH_OUT_U)
		   + round_mul(coef_hi(coef_bank[sosf_pkg::REG_C_ROW_SECOND]), x0, SH_OUT_X)
		   + round_mul(coef_lo(coef_bank[sosf_pkg::REG_C_ROW_SECOND]), x1, SH_OUT_X);
		n0 = round_mul(coef_hi(coef_bank[sosf_pkg::REG_B_PAIR]), u, SH_ST_U)
		   + round_mul(coef_hi(coef_bank[sosf_pkg::REG_A_ROW_FIRST]), x0, SH_ST_X)
		   + round_mul(coef_lo(coef_bank[sosf_pkg::REG_A_ROW_FIRST]), x1, SH_ST_X);
		n1 = round_mul(coef_lo(coef_bank[sosf_pkg::REG_B_PAIR]), u, SH_ST_U)
		   + round_mul(coef_hi(coef_bank[sosf_pkg::REG_A_ROW_SECOND]), x0, SH_ST_X)
		   + round_mul(coef_lo(coef_bank[sosf_pkg::REG_A_ROW_SECOND]), x1, SH_ST_X);
		y0 = clamp_signed(y0, 16, clipped);
		y1 = clamp_signed(y1, 16, clipped);
		state_first_q = clamp_signed(n0, 32, clipped);
		state_second_q = clamp_signed(n1, 32, clipped);
		r.in_phase = y0[15:0];
		r.quadrature = y1[15:0];
		r.saturated = clipped;
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic send_sample(input logic signed [15:0] value);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_outputs.push_back(advance_filter(value));
	endtask

	// drop valid after the last beat of a burst
	task automatic finish_burst();
		in_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx < NUM_COEF_REGS)
			coef_bank[idx] = data;
	endtask

	task automatic load_filter(input logic [63:0] a_first, a_second, b, c_first, c_second, d);
		wait_idle();
		write_reg(sosf_pkg::REG_A_ROW_FIRST, a_first);
		write_reg(sosf_pkg::REG_A_ROW_SECOND, a_second);
		write_reg(sosf_pkg::REG_B_PAIR, b);
		write_reg(sosf_pkg::REG_C_ROW_FIRST, c_first);
		write_reg(sosf_pkg::REG_C_ROW_SECOND, c_second);
		write_reg(sosf_pkg::REG_D_PAIR, d);
		// unmapped indexes must leave the bank alone
		write_reg(IDX_SPARE_SIX, {$urandom, $urandom});
		write_reg(IDX_SPARE_SEVEN, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_sample();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return 16'($urandom);
		if (pick < 85)
			return 16'(int'($urandom_range(0, 512)) - 256);
		case ($urandom_range(3))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return -16'sd1;
		endcase
	endfunction

	function automatic logic [63:0] rand_pair(bit narrow);
		if (narrow)
			return {32'(int'($urandom_range(0, 2 ** 28)) - 2 ** 27),
				32'(int'($urandom_range(0, 2 ** 28)) - 2 ** 27)};
		return {$urandom, $urandom};
	endfunction

	task automatic run_stream(input int count, input int hold_at);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				-> long_hold_go;
			send_sample(rand_sample());
		end
		finish_burst();
	endtask

	// ---------------------------------------------------------------- sink side

	initial begin
		forever begin
			@(long_hold_go);
			@(posedge clk);
			long_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			long_hold <= 1'b0;
		end
	end

	always @(posedge clk)
		out_stall <= long_hold || (!no_idle && $urandom_range(99) < IDLE_PCT);

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("result %0d %s: got %0d, want %0d", result_count, what, got, want);
	endtask

	always @(posedge clk) begin : check_beat
		filter_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				want = pending_outputs.pop_front();
				if (in_phase !== want.in_phase)
					report_mismatch("in_phase", in_phase, want.in_phase);
				if (quadrature !== want.quadrature)
					report_mismatch("quadrature", quadrature, want.quadrature);
				if (saturated !== want.saturated)
					report_mismatch("saturated", saturated, want.saturated);
			end
			result_count++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// all coefficients still at their reset value of zero
	task automatic test_reset_defaults();
		logic signed [15:0] vals [4] = '{16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF};
		foreach (vals[i])
			send_sample(vals[i]);
		finish_burst();
	endtask

	// half-weight direct path: odd samples land exactly on a rounding tie
	task automatic test_rounding_ties();
		logic signed [15:0] vals [8] = '{16'sd1, -16'sd1, 16'sd3, -16'sd3,
			16'sh7FFF, 16'sh8000, 16'sd0, 16'sd2};
		load_filter(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, {Q28_HALF, Q28_NEG_HALF});
		foreach (vals[i])
			send_sample(vals[i]);
		finish_burst();
	endtask

	// largest direct gains of both signs clip the outputs
	task automatic test_output_saturation();
		logic signed [15:0] vals [6] = '{16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1,
			16'sd4096, -16'sd4096};
		load_filter(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, {COEF_MAX, COEF_MIN});
		foreach (vals[i])
			send_sample(vals[i]);
		finish_burst();
	endtask

	// extreme transition and input gains drive the state into its rails
	task automatic test_state_saturation();
		logic signed [15:0] vals [6] = '{16'sh7FFF, 16'sd0, 16'sd0, 16'sh8000,
			16'sd0, 16'sd0};
		load_filter({COEF_MAX, COEF_MIN}, {COEF_MIN, COEF_MAX}, {COEF_MAX, COEF_MIN},
			{Q28_ONE, ZERO_COEF}, {ZERO_COEF, COEF_MIN}, 64'd0);
		foreach (vals[i])
			send_sample(vals[i]);
		finish_burst();
	endtask

	// damped rotation, back to back on both sides
	task automatic test_resonator_steady();
		load_filter({32'd255013683, 32'hFC00_0000}, {32'h0400_0000, 32'd255013683},
			{32'd13421773, 32'd13421773}, {Q28_ONE, ZERO_COEF}, {ZERO_COEF, Q28_ONE},
			{Q28_EIGHTH, ZERO_COEF});
		no_idle <= 1'b1;
		run_stream(300, -1);
		wait_idle();
		no_idle <= 1'b0;
	endtask

	// same filter with random gaps and one long receiver hold-off
	task automatic test_resonator_backpressure();
		run_stream(300, 60);
	endtask

	// lightly damped resonance near the unit circle
	task automatic test_resonator_narrow();
		load_filter({32'd267898585, 32'(-13421773)}, {32'd13421773, 32'd267898585},
			{32'd13421773, 32'(-13421773)}, {Q28_ONE, Q28_EIGHTH}, {Q28_EIGHTH, Q28_ONE},
			{ZERO_COEF, Q28_EIGHTH});
		run_stream(250, -1);
	endtask

	task automatic test_random_coefs(input bit narrow);
		for (int k = 0; k < 2; k++) begin
			load_filter(rand_pair(narrow), rand_pair(narrow), rand_pair(narrow),
				rand_pair(narrow), rand_pair(narrow), rand_pair(narrow));
			run_stream(100, -1);
		end
	endtask

	initial begin
		foreach (coef_bank[i])
			coef_bank[i] = '0;
		state_first_q = 0;
		state_second_q = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_rounding_ties();
		test_output_saturation();
		test_state_saturation();
		test_resonator_steady();
		test_resonator_backpressure();
		test_resonator_narrow();
		test_random_coefs(1'b0);
		test_random_coefs(1'b1);

		wait_idle();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sosf_pkg.sv
hw/rtl/sosf_term.sv
hw/rtl/second_order_state_space_filter_unit.sv
hw/rtl/sosf_checker.sv
tb/tb_second_order_state_space_filter_unit.sv
